// ----- sv/sarq_pkg.sv -----
// shared types and constants for the shortest-arc quaternion unit
package sarq_pkg;

   // unit vectors are Q2.30, products of unit components are Q60
   localparam int UNIT_BITS   = 30;
   localparam int DIV_STEPS   = 2 * UNIT_BITS;
   localparam int ROOT_W      = UNIT_BITS + 1;
   localparam int LANE_LAT    = DIV_STEPS + ROOT_W + 1;
   localparam int UNIT_W      = 32;
   localparam int PROD_W      = 64;
   localparam int QUAT_W      = 16;
   localparam int QUAT_W_W    = 15;
   localparam int REF_Z_RESET = 16384;

   // register indexes
   localparam logic [1:0] REG_REF_X = 2'd0;
   localparam logic [1:0] REG_REF_Y = 2'd1;
   localparam logic [1:0] REG_REF_Z = 2'd2;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_ZERO = 2'd1;
   localparam status_type ST_ANTI = 2'd2;

   // control that travels with an item down the pipeline
   typedef struct packed {
      logic       valid;
      status_type status;
   } tag_type;

   // one result item
   typedef struct packed {
      logic [QUAT_W-1:0]   quat_x;
      logic [QUAT_W-1:0]   quat_y;
      logic [QUAT_W-1:0]   quat_z;
      logic [QUAT_W_W-1:0] quat_w;
      status_type          status;
   } result_type;

endpackage

// ----- sv/sarq_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module sarq_isqrt #(
   parameter int RW = 31
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-2:0] x_i,
   output logic [RW-1:0]   root_o
);

   localparam int VW = 2 * RW;

   logic [VW-1:0] x_ff   [RW];
   logic [VW-1:0] res_ff [RW];

   genvar i;
   generate
      for (i = 0; i < RW; i++) begin : g_step
         logic [VW-1:0] x_src;
         logic [VW-1:0] res_src;
         logic [VW-1:0] bit_v;
         logic [VW-1:0] sum;
         logic [VW-1:0] x_in;
         logic [VW-1:0] res_in;

         if (i == 0) begin : g_first
            assign x_src   = VW'(x_i);
            assign res_src = '0;
         end else begin : g_next
            assign x_src   = x_ff[i-1];
            assign res_src = res_ff[i-1];
         end

         assign bit_v = VW'(1) << (2 * (RW - 1 - i));
         assign sum   = res_src + bit_v;

         // trial subtract of the next root digit
         always_comb begin
            if (x_src >= sum) begin
               x_in   = x_src - sum;
               res_in = (res_src >> 1) + bit_v;
            end else begin
               x_in   = x_src;
               res_in = res_src >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i]   <= x_in;
               res_ff[i] <= res_in;
            end
         end
      end
   endgenerate

   assign root_o = res_ff[RW-1][RW-1:0];

endmodule

// ----- sv/sarq_lane.sv -----
// one normalization lane: component^2 / length^2 divider, square root, sign
module sarq_lane
   import sarq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [2*SAMPLE_WIDTH-1:0] num_i,
   input  logic [2*SAMPLE_WIDTH+1:0] den_i,
   input  logic                      neg_i,
   output logic signed [UNIT_W-1:0]  unit_o
);

   localparam int DW = 2 * SAMPLE_WIDTH + 2;
   localparam int XW = 2 * ROOT_W - 1;

   logic [DW-1:0]        r_ff   [DIV_STEPS];
   logic [DW-1:0]        den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS];
   logic                 neg_ff [DIV_STEPS];
   logic                 eq_ff  [DIV_STEPS];

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_div
         logic [DW-1:0]        r_src;
         logic [DW-1:0]        den_src;
         logic [DIV_STEPS-1:0] q_src;
         logic                 neg_src;
         logic                 eq_src;
         logic [DW:0]          r2;
         logic [DW:0]          diff;
         logic                 ge;
         logic [DW-1:0]        r_in;

         if (k == 0) begin : g_first
            assign r_src   = DW'(num_i);
            assign den_src = den_i;
            assign q_src   = '0;
            assign neg_src = neg_i;
            assign eq_src  = (DW'(num_i) >= den_i);
         end else begin : g_next
            assign r_src   = r_ff[k-1];
            assign den_src = den_ff[k-1];
            assign q_src   = q_ff[k-1];
            assign neg_src = neg_ff[k-1];
            assign eq_src  = eq_ff[k-1];
         end

         // restoring division, one quotient bit per stage
         assign r2   = {r_src, 1'b0};
         assign diff = r2 - {1'b0, den_src};
         assign ge   = (r2 >= {1'b0, den_src});
         assign r_in = ge ? diff[DW-1:0] : r2[DW-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k]   <= r_in;
               den_ff[k] <= den_src;
               q_ff[k]   <= {q_src[DIV_STEPS-2:0], ge};
               neg_ff[k] <= neg_src;
               eq_ff[k]  <= eq_src;
            end
         end
      end
   endgenerate

   // full-length component gives exactly one
   logic [XW-1:0]     sqrt_x;
   logic [ROOT_W-1:0] root;

   assign sqrt_x = eq_ff[DIV_STEPS-1] ? (XW'(1) << DIV_STEPS) : XW'(q_ff[DIV_STEPS-1]);

   sarq_isqrt #(
      .RW (ROOT_W)
   ) u_isqrt (
      .clock  (clock),
      .en     (en),
      .x_i    (sqrt_x),
      .root_o (root)
   );

   // sign follows the root through its pipeline
   logic sneg_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sneg_ff[0] <= neg_ff[DIV_STEPS-1];
         for (int j = 1; j < ROOT_W; j++) begin
            sneg_ff[j] <= sneg_ff[j-1];
         end
      end
   end

   // apply the sign
   logic signed [UNIT_W-1:0] mag;
   logic signed [UNIT_W-1:0] unit_in;
   logic signed [UNIT_W-1:0] unit_ff;

   assign mag     = $signed(UNIT_W'(root));
   assign unit_in = sneg_ff[ROOT_W-1] ? -mag : mag;

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_o = unit_ff;

endmodule

// ----- sv/sarq_merge.sv -----
// merging stage: unit cross and dot, half-angle root, rounded quotient, saturation
module sarq_merge
   import sarq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  tag_type                  tag_i,
   input  logic signed [UNIT_W-1:0] ua_i [3],
   input  logic signed [UNIT_W-1:0] ub_i [3],
   output tag_type                  tag_o,
   output result_type               res_o
);

   localparam int HW = 2 * ROOT_W - 1;
   localparam int QS = FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] CAP = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   typedef struct packed {
      tag_type            tag;
      logic [2:0]         neg;
      logic [2:0]         ovf;
      logic [FRAC_BITS:0] wq;
      logic [ROOT_W-1:0]  w;
   } side_type;

   // products of unit components
   logic signed [PROD_W-1:0] prod_ff [3][3];
   tag_type                  tag1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= PROD_W'(ua_i[i] * ub_i[j]);
            end
         end
      end
   end

   // cross and dot in Q60
   logic signed [PROD_W-1:0] cross_ff [3];
   logic signed [PROD_W-1:0] dot_ff;
   tag_type                  tag2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cross_ff[0] <= prod_ff[1][2] - prod_ff[2][1];
         cross_ff[1] <= prod_ff[2][0] - prod_ff[0][2];
         cross_ff[2] <= prod_ff[0][1] - prod_ff[1][0];
         dot_ff      <= prod_ff[0][0] + prod_ff[1][1] + prod_ff[2][2];
      end
   end

   // h = (1 + cos) / 2, clamped to [0, 1]
   logic signed [PROD_W-1:0] hsum;
   logic [PROD_W-1:0]        hhalf;
   logic [HW-1:0]            h_in;
   logic [HW-1:0]            h_ff;
   logic signed [PROD_W-1:0] cross3_ff [3];
   tag_type                  tag3_ff;

   assign hsum  = dot_ff + (PROD_W'(1) << DIV_STEPS);
   assign hhalf = $unsigned(hsum) >> 1;

   always_comb begin
      if (hsum[PROD_W-1]) begin
         h_in = '0;
      end else if (hhalf > (PROD_W'(1) << DIV_STEPS)) begin
         h_in = HW'(1) << DIV_STEPS;
      end else begin
         h_in = hhalf[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff <= h_in;
         for (int i = 0; i < 3; i++) begin
            cross3_ff[i] <= cross_ff[i];
         end
      end
   end

   // half-angle cosine
   logic [ROOT_W-1:0] w_root;

   sarq_isqrt #(
      .RW (ROOT_W)
   ) u_isqrt (
      .clock  (clock),
      .en     (en),
      .x_i    (h_ff),
      .root_o (w_root)
   );

   logic signed [PROD_W-1:0] cd_ff [ROOT_W][3];
   tag_type                  td_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cd_ff[0][i] <= cross3_ff[i];
         end
         for (int s = 1; s < ROOT_W; s++) begin
            for (int i = 0; i < 3; i++) begin
               cd_ff[s][i] <= cd_ff[s-1][i];
            end
         end
      end
   end

   // control through the first stages and the root pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         for (int s = 0; s < ROOT_W; s++) begin
            td_ff[s] <= '0;
         end
      end else if (en) begin
         tag1_ff  <= tag_i;
         tag2_ff  <= tag1_ff;
         tag3_ff  <= tag2_ff;
         td_ff[0] <= tag3_ff;
         for (int s = 1; s < ROOT_W; s++) begin
            td_ff[s] <= td_ff[s-1];
         end
      end
   end

   // dividend with rounding half, overflow check, scalar part
   logic [PROD_W-1:0]  w64;
   logic [PROD_W-1:0]  half_d;
   logic [PROD_W-1:0]  num4 [3];
   logic [UNIT_W-1:0]  wr;
   side_type           side4_in;
   logic [PROD_W-1:0]  num4_ff [3];
   side_type           side4_ff;

   assign w64    = PROD_W'(w_root);
   assign half_d = w64 << (UNIT_BITS - FRAC_BITS);
   assign wr     = (UNIT_W'(w_root) + (UNIT_W'(1) << (UNIT_BITS - 1 - FRAC_BITS)))
                   >> (UNIT_BITS - FRAC_BITS);

   always_comb begin
      side4_in            = '0;
      side4_in.tag        = td_ff[ROOT_W-1];
      side4_in.w          = w_root;
      side4_in.wq         = (wr > UNIT_W'(CAP)) ? CAP : wr[FRAC_BITS:0];
      if (td_ff[ROOT_W-1].status == ST_OK && w_root == '0) begin
         side4_in.tag.status = ST_ANTI;
      end
      for (int i = 0; i < 3; i++) begin
         side4_in.neg[i] = cd_ff[ROOT_W-1][i][PROD_W-1];
         num4[i] = (side4_in.neg[i] ? PROD_W'(-cd_ff[ROOT_W-1][i])
                                    : PROD_W'(cd_ff[ROOT_W-1][i])) + half_d;
         side4_in.ovf[i] = (num4[i] >= (w64 << (UNIT_BITS + 2)));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num4_ff[i] <= num4[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff <= '0;
      end else if (en) begin
         side4_ff <= side4_in;
      end
   end

   // quotient digits, most significant first
   logic [PROD_W-1:0]    rem_ff  [QS][3];
   logic [FRAC_BITS:0]   qb_ff   [QS][3];
   side_type             side_ff [QS];

   genvar j;
   generate
      for (j = 0; j < QS; j++) begin : g_quot
         logic [PROD_W-1:0]  rem_src [3];
         logic [FRAC_BITS:0] q_src   [3];
         side_type           side_src;
         logic [PROD_W-1:0]  cmp;
         logic [PROD_W-1:0]  rem_in  [3];
         logic [FRAC_BITS:0] q_in    [3];

         if (j == 0) begin : g_first
            assign side_src = side4_ff;
            for (genvar i = 0; i < 3; i++) begin : g_lane
               assign rem_src[i] = num4_ff[i];
               assign q_src[i]   = '0;
            end
         end else begin : g_next
            assign side_src = side_ff[j-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
               assign rem_src[i] = rem_ff[j-1][i];
               assign q_src[i]   = qb_ff[j-1][i];
            end
         end

         assign cmp = PROD_W'(side_src.w) << (UNIT_BITS + 1 - j);

         always_comb begin
            for (int i = 0; i < 3; i++) begin
               if (rem_src[i] >= cmp) begin
                  rem_in[i] = rem_src[i] - cmp;
                  q_in[i]   = {q_src[i][FRAC_BITS-1:0], 1'b1};
               end else begin
                  rem_in[i] = rem_src[i];
                  q_in[i]   = {q_src[i][FRAC_BITS-1:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               for (int i = 0; i < 3; i++) begin
                  rem_ff[j][i] <= rem_in[i];
                  qb_ff[j][i]  <= q_in[i];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[j] <= '0;
            end else if (en) begin
               side_ff[j] <= side_src;
            end
         end
      end
   endgenerate

   // saturate, apply sign, zero the fields of a flagged item
   side_type           side_l;
   logic [FRAC_BITS:0] mag   [3];
   logic [QUAT_W-1:0]  quat  [3];
   result_type         res_in;
   result_type         res_ff;
   tag_type            tag_out_ff;

   assign side_l = side_ff[QS-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (side_l.ovf[i] || qb_ff[QS-1][i] > CAP) begin
            mag[i] = CAP;
         end else begin
            mag[i] = qb_ff[QS-1][i];
         end
         quat[i] = side_l.neg[i] ? (QUAT_W'(0) - QUAT_W'(mag[i])) : QUAT_W'(mag[i]);
      end
      res_in        = '0;
      res_in.status = side_l.tag.status;
      if (side_l.tag.status == ST_OK) begin
         res_in.quat_x = quat[0];
         res_in.quat_y = quat[1];
         res_in.quat_z = quat[2];
         res_in.quat_w = QUAT_W_W'(side_l.wq);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (en) begin
         tag_out_ff <= side_l.tag;
      end
   end

   assign tag_o = tag_out_ff;
   assign res_o = res_ff;

endmodule

// ----- sv/shortest_arc_quaternion_unit.sv -----
// throughput: one item per cycle while the skid entry is empty; the whole pipeline advances together
// the 60-step normalization dividers and two 31-step square roots set the depth
// a two-entry output stage lets one more item in while a result is held
// synchronous active-high reset clears all valid state and sets ref to (0, 0, 16384)
module shortest_arc_quaternion_unit
   import sarq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_mag_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_mag_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_mag_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [QUAT_W-1:0]       rsp_quat_x,
   output logic signed [QUAT_W-1:0]       rsp_quat_y,
   output logic signed [QUAT_W-1:0]       rsp_quat_z,
   output logic [QUAT_W_W-1:0]            rsp_quat_w,
   output logic [1:0]                     rsp_result_status,
   input  logic                           csr_write,
   input  logic [1:0]                     csr_index,
   input  logic [SAMPLE_WIDTH-1:0]        csr_data
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int NW = 2 * SW;
   localparam int DW = 2 * SW + 2;

   // reference vector registers
   logic signed [SW-1:0] ref_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff[0] <= '0;
         ref_ff[1] <= '0;
         ref_ff[2] <= SW'(REF_Z_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_REF_X: ref_ff[0] <= csr_data;
            REG_REF_Y: ref_ff[1] <= csr_data;
            REG_REF_Z: ref_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance; held only while the skid entry is occupied
   logic skid_v_ff;
   logic en;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // stage 1: squares and raw products
   logic signed [SW-1:0] a [3];
   logic [NW-1:0]        sqa1_ff [3];
   logic [NW-1:0]        sqb1_ff [3];
   logic signed [NW-1:0] p1_ff   [3][3];
   logic [2:0]           nega1_ff;
   logic [2:0]           negb1_ff;
   logic                 zero1_ff;
   logic                 v1_ff;

   assign a[0] = req_mag_x;
   assign a[1] = req_mag_y;
   assign a[2] = req_mag_z;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sqa1_ff[i]  <= NW'(a[i] * a[i]);
            sqb1_ff[i]  <= NW'(ref_ff[i] * ref_ff[i]);
            nega1_ff[i] <= a[i][SW-1];
            negb1_ff[i] <= ref_ff[i][SW-1];
            for (int j = 0; j < 3; j++) begin
               p1_ff[i][j] <= NW'(a[i] * ref_ff[j]);
            end
         end
         zero1_ff <= (a[0] == '0 && a[1] == '0 && a[2] == '0) ||
                     (ref_ff[0] == '0 && ref_ff[1] == '0 && ref_ff[2] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   // stage 2: squared lengths and the degenerate-case status
   logic signed [NW:0]   rc [3];
   logic signed [NW+1:0] rdot;
   logic [DW-1:0]        suma2_ff;
   logic [DW-1:0]        sumb2_ff;
   logic [NW-1:0]        sqa2_ff [3];
   logic [NW-1:0]        sqb2_ff [3];
   logic [2:0]           nega2_ff;
   logic [2:0]           negb2_ff;
   status_type           st2_in;
   tag_type              tag2_ff;

   assign rc[0] = (NW+1)'(p1_ff[1][2]) - (NW+1)'(p1_ff[2][1]);
   assign rc[1] = (NW+1)'(p1_ff[2][0]) - (NW+1)'(p1_ff[0][2]);
   assign rc[2] = (NW+1)'(p1_ff[0][1]) - (NW+1)'(p1_ff[1][0]);
   assign rdot  = (NW+2)'(p1_ff[0][0]) + (NW+2)'(p1_ff[1][1]) + (NW+2)'(p1_ff[2][2]);

   always_comb begin
      priority if (zero1_ff) begin
         st2_in = ST_ZERO;
      end else if (rc[0] == '0 && rc[1] == '0 && rc[2] == '0 && rdot[NW+1]) begin
         st2_in = ST_ANTI;
      end else begin
         st2_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         suma2_ff <= DW'(sqa1_ff[0]) + DW'(sqa1_ff[1]) + DW'(sqa1_ff[2]);
         sumb2_ff <= DW'(sqb1_ff[0]) + DW'(sqb1_ff[1]) + DW'(sqb1_ff[2]);
         for (int i = 0; i < 3; i++) begin
            sqa2_ff[i] <= sqa1_ff[i];
            sqb2_ff[i] <= sqb1_ff[i];
         end
         nega2_ff <= nega1_ff;
         negb2_ff <= negb1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
      end else if (en) begin
         tag2_ff.valid  <= v1_ff;
         tag2_ff.status <= st2_in;
      end
   end

   // six normalization lanes, three per vector
   logic signed [UNIT_W-1:0] ua [3];
   logic signed [UNIT_W-1:0] ub [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lanes
         sarq_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_lane_a (
            .clock  (clock),
            .en     (en),
            .num_i  (sqa2_ff[g]),
            .den_i  (suma2_ff),
            .neg_i  (nega2_ff[g]),
            .unit_o (ua[g])
         );

         sarq_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_lane_b (
            .clock  (clock),
            .en     (en),
            .num_i  (sqb2_ff[g]),
            .den_i  (sumb2_ff),
            .neg_i  (negb2_ff[g]),
            .unit_o (ub[g])
         );
      end
   endgenerate

   // control alongside the lanes
   tag_type tagl_ff [LANE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            tagl_ff[s] <= '0;
         end
      end else if (en) begin
         tagl_ff[0] <= tag2_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            tagl_ff[s] <= tagl_ff[s-1];
         end
      end
   end

   // merging stage
   tag_type    pipe_tag;
   result_type pipe_res;

   sarq_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .tag_i (tagl_ff[LANE_LAT-1]),
      .ua_i  (ua),
      .ub_i  (ub),
      .tag_o (pipe_tag),
      .res_o (pipe_res)
   );

   // output register with one skid entry
   result_type out_ff;
   result_type skid_ff;
   logic       out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         priority if (skid_v_ff) begin
            if (!rsp_stall) begin
               skid_v_ff <= 1'b0;
            end
         end else if (pipe_tag.valid) begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_ff <= 1'b1;
            end else begin
               skid_v_ff <= 1'b1;
            end
         end else begin
            if (!rsp_stall) begin
               out_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_ff <= skid_ff;
         end
      end else begin
         if (pipe_tag.valid) begin
            if (!out_v_ff || !rsp_stall) begin
               out_ff <= pipe_res;
            end else begin
               skid_ff <= pipe_res;
            end
         end
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_quat_x        = out_ff.quat_x;
   assign rsp_quat_y        = out_ff.quat_y;
   assign rsp_quat_z        = out_ff.quat_z;
   assign rsp_quat_w        = out_ff.quat_w;
   assign rsp_result_status = out_ff.status;

endmodule
